// ===== design/assert_macros.svh =====
// Assertion macros used by the asserting design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== design/mrtu_pkg.sv =====
// Package for the Modbus RTU master frame engine: codes, types and the CRC step.
package mrtu_pkg;

   localparam logic [15:0] CRC_INIT           = 16'hFFFF;
   localparam logic [15:0] CRC_POLY           = 16'hA001;
   localparam logic [7:0]  FN_READ            = 8'h03;
   localparam logic [7:0]  FN_WRITE           = 8'h06;
   localparam logic [7:0]  BYTE_COUNT_ONE_REG = 8'h02;
   localparam logic [15:0] READ_COUNT_ONE     = 16'h0001;
   localparam logic [7:0]  ADDR_RESET         = 8'd1;
   localparam logic [15:0] TIMEOUT_RESET      = 16'd100;

   typedef logic [1:0] mode_type;
   typedef logic [1:0] status_type;
   typedef logic [2:0] byte_idx_type;

   localparam mode_type MODE_READ  = 2'd0;
   localparam mode_type MODE_WRITE = 2'd1;
   localparam mode_type MODE_BYTE  = 2'd2;
   localparam mode_type MODE_TICK  = 2'd3;

   localparam logic KIND_TX     = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   localparam status_type STATUS_OK      = 2'd0;
   localparam status_type STATUS_TIMEOUT = 2'd1;
   localparam status_type STATUS_CRC     = 2'd2;
   localparam status_type STATUS_INVALID = 2'd3;

   localparam logic CSR_SERVER_ADDRESS = 1'b0;
   localparam logic CSR_TIMEOUT_TICKS  = 1'b1;

   // Frame byte positions.
   localparam byte_idx_type IDX_ADDR    = 3'd0;
   localparam byte_idx_type IDX_FN      = 3'd1;
   localparam byte_idx_type IDX_REG_HI  = 3'd2;
   localparam byte_idx_type IDX_REG_LO  = 3'd3;
   localparam byte_idx_type IDX_WORD_HI = 3'd4;
   localparam byte_idx_type IDX_WORD_LO = 3'd5;
   localparam byte_idx_type IDX_CRC_LO  = 3'd6;
   localparam byte_idx_type IDX_CRC_HI  = 3'd7;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [7:0]  server_address;
      logic [15:0] timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic        is_report;
      logic        is_write;
      logic [7:0]  addr;
      logic [15:0] reg_addr;
      logic [15:0] word;
      status_type  status;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

   typedef struct packed {
      logic              full;
      logic              has_data;
      logic [QCNT_W-1:0] count;
   } qstat_type;

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ===== design/mrtu_req_if.sv =====
// Request channel interface: valid, ready and one input event.
interface mrtu_req_if;
   import mrtu_pkg::*;

   logic        valid;
   logic        ready;
   mode_type    mode;
   logic [15:0] register_address;
   logic [15:0] write_value;
   logic [7:0]  line_byte;

   modport source (output valid, mode, register_address, write_value, line_byte,
                   input ready);
   modport sink   (input valid, mode, register_address, write_value, line_byte,
                   output ready);
endinterface

// ===== design/mrtu_rsp_if.sv =====
// Result channel interface: valid, ready and one result item.
interface mrtu_rsp_if;
   import mrtu_pkg::*;

   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  tx_byte;
   logic        last;
   status_type  status;
   logic [15:0] read_value;

   modport source (output valid, kind, tx_byte, last, status, read_value,
                   input ready);
   modport sink   (input valid, kind, tx_byte, last, status, read_value,
                   output ready);
endinterface

// ===== design/mrtu_front.sv =====
// Front end: accepts events, tracks the transaction and queues frame and report jobs.
module mrtu_front (
   input  logic               clock,
   input  logic               reset,
   input  mrtu_pkg::cfg_type  cfg,
   input  mrtu_pkg::qstat_type q_stat,
   output mrtu_pkg::push_type q_push,
   mrtu_req_if.sink           req_ch
);
   import mrtu_pkg::*;

   logic         busy_ff, busy_in;
   logic         is_write_ff, is_write_in;
   logic [7:0]   addr_ff, addr_in;
   logic [15:0]  reg_ff, reg_in;
   logic [15:0]  word_ff, word_in;
   byte_idx_type count_ff, count_in;
   logic [15:0]  crc_ff, crc_in;
   logic [15:0]  wait_ff, wait_in;
   logic         bad_ff, bad_in;
   logic [15:0]  data_ff, data_in;
   logic [7:0]   crclo_ff, crclo_in;

   logic         acc;
   logic [7:0]   exp_byte;
   logic [7:0]   fn_byte;
   byte_idx_type last_idx;
   byte_idx_type crc_stop;
   logic [15:0]  wait_next;

   assign req_ch.ready = !q_stat.full;
   assign acc          = req_ch.valid && req_ch.ready;
   assign fn_byte      = is_write_ff ? FN_WRITE : FN_READ;
   assign last_idx     = is_write_ff ? IDX_CRC_HI : IDX_CRC_LO;
   assign crc_stop     = is_write_ff ? IDX_CRC_LO : IDX_WORD_LO;
   assign wait_next    = (wait_ff == 16'hFFFF) ? wait_ff : wait_ff + 16'd1;

   always_comb begin
      case (count_ff)
         IDX_ADDR:    exp_byte = addr_ff;
         IDX_FN:      exp_byte = fn_byte;
         IDX_REG_HI:  exp_byte = is_write_ff ? reg_ff[15:8] : BYTE_COUNT_ONE_REG;
         IDX_REG_LO:  exp_byte = reg_ff[7:0];
         IDX_WORD_HI: exp_byte = word_ff[15:8];
         IDX_WORD_LO: exp_byte = word_ff[7:0];
         IDX_CRC_LO:  exp_byte = crc_ff[7:0];
         IDX_CRC_HI:  exp_byte = crc_ff[15:8];
         default:     exp_byte = 8'h00;
      endcase
   end

   always_comb begin
      busy_in     = busy_ff;
      is_write_in = is_write_ff;
      addr_in     = addr_ff;
      reg_in      = reg_ff;
      word_in     = word_ff;
      count_in    = count_ff;
      crc_in      = crc_ff;
      wait_in     = wait_ff;
      bad_in      = bad_ff;
      data_in     = data_ff;
      crclo_in    = crclo_ff;

      q_push                 = '0;
      q_push.entry.is_report = KIND_REPORT;
      q_push.entry.status    = STATUS_OK;

      if (acc) begin
         case (req_ch.mode)
            MODE_READ, MODE_WRITE: begin
               if (!busy_ff) begin
                  busy_in     = 1'b1;
                  is_write_in = (req_ch.mode == MODE_WRITE);
                  addr_in     = cfg.server_address;
                  reg_in      = req_ch.register_address;
                  word_in     = is_write_in ? req_ch.write_value : READ_COUNT_ONE;
                  count_in    = IDX_ADDR;
                  crc_in      = CRC_INIT;
                  wait_in     = 16'h0000;
                  bad_in      = 1'b0;
                  q_push.valid           = 1'b1;
                  q_push.entry.is_report = KIND_TX;
                  q_push.entry.is_write  = is_write_in;
                  q_push.entry.addr      = addr_in;
                  q_push.entry.reg_addr  = reg_in;
                  q_push.entry.word      = word_in;
               end
            end
            MODE_TICK: begin
               if (busy_ff) begin
                  wait_in = wait_next;
                  if (wait_next >= cfg.timeout_ticks) begin
                     busy_in             = 1'b0;
                     q_push.valid        = 1'b1;
                     q_push.entry.status = STATUS_TIMEOUT;
                  end
               end
            end
            MODE_BYTE: begin
               if (busy_ff) begin
                  bad_in = bad_ff | ((req_ch.line_byte != exp_byte) &&
                                     (is_write_ff || count_ff < IDX_REG_LO));
                  if (count_ff < crc_stop) begin
                     crc_in = crc16_byte(crc_ff, req_ch.line_byte);
                  end
                  if (count_ff == IDX_REG_LO) begin
                     data_in[15:8] = req_ch.line_byte;
                  end
                  if (count_ff == IDX_WORD_HI) begin
                     data_in[7:0] = req_ch.line_byte;
                  end
                  if (count_ff == IDX_WORD_LO) begin
                     crclo_in = req_ch.line_byte;
                  end
                  count_in = count_ff + 3'd1;
                  if (count_ff == last_idx) begin
                     busy_in      = 1'b0;
                     q_push.valid = 1'b1;
                     if (is_write_ff) begin
                        q_push.entry.status = bad_in ? STATUS_INVALID : STATUS_OK;
                     end else if ({req_ch.line_byte, crclo_ff} != crc_ff) begin
                        q_push.entry.status = STATUS_CRC;
                     end else if (bad_ff) begin
                        q_push.entry.status = STATUS_INVALID;
                     end else begin
                        q_push.entry.word = data_ff;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         is_write_ff <= 1'b0;
         count_ff    <= IDX_ADDR;
         crc_ff      <= CRC_INIT;
         wait_ff     <= 16'h0000;
         bad_ff      <= 1'b0;
      end else begin
         busy_ff     <= busy_in;
         is_write_ff <= is_write_in;
         count_ff    <= count_in;
         crc_ff      <= crc_in;
         wait_ff     <= wait_in;
         bad_ff      <= bad_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff  <= addr_in;
      reg_ff   <= reg_in;
      word_ff  <= word_in;
      data_ff  <= data_in;
      crclo_ff <= crclo_in;
   end

endmodule

// ===== design/mrtu_queue.sv =====
// Job queue between the front end and the back end.
module mrtu_queue (
   input  logic                clock,
   input  logic                reset,
   input  mrtu_pkg::push_type  q_push,
   input  logic                pop,
   output mrtu_pkg::entry_type head,
   output mrtu_pkg::qstat_type q_stat
);
   import mrtu_pkg::*;

   entry_type         mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign q_stat.count    = count_ff;
   assign q_stat.full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_stat.has_data = (count_ff != '0);
   assign head            = mem_ff[rd_ptr_ff];

   assign do_push = q_push.valid && !q_stat.full;
   assign do_pop  = pop && q_stat.has_data;

   always_comb begin
      wr_ptr_in = do_push ? QPTR_W'((32'(wr_ptr_ff) + 1) % QUEUE_DEPTH) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? QPTR_W'((32'(rd_ptr_ff) + 1) % QUEUE_DEPTH) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= q_push.entry;
      end
   end

endmodule

// ===== design/mrtu_back.sv =====
// Back end: expands queued jobs into frame bytes or reports and drives the result channel.
module mrtu_back (
   input  logic                clock,
   input  logic                reset,
   input  mrtu_pkg::entry_type head,
   input  mrtu_pkg::qstat_type q_stat,
   output logic                pop,
   mrtu_rsp_if.source          rsp_ch
);
   import mrtu_pkg::*;

   byte_idx_type idx_ff, idx_in;
   logic [15:0]  crc_ff, crc_in;
   logic         valid_ff, valid_in;
   logic         kind_ff, kind_in;
   logic [7:0]   tx_ff, tx_in;
   logic         last_ff, last_in;
   status_type   status_ff, status_in;
   logic [15:0]  value_ff, value_in;

   logic         adv;
   logic [7:0]   frame_byte;

   assign adv = q_stat.has_data && (!valid_ff || rsp_ch.ready);

   assign rsp_ch.valid      = valid_ff;
   assign rsp_ch.kind       = kind_ff;
   assign rsp_ch.tx_byte    = tx_ff;
   assign rsp_ch.last       = last_ff;
   assign rsp_ch.status     = status_ff;
   assign rsp_ch.read_value = value_ff;

   always_comb begin
      case (idx_ff)
         IDX_ADDR:    frame_byte = head.addr;
         IDX_FN:      frame_byte = head.is_write ? FN_WRITE : FN_READ;
         IDX_REG_HI:  frame_byte = head.reg_addr[15:8];
         IDX_REG_LO:  frame_byte = head.reg_addr[7:0];
         IDX_WORD_HI: frame_byte = head.word[15:8];
         IDX_WORD_LO: frame_byte = head.word[7:0];
         IDX_CRC_LO:  frame_byte = crc_ff[7:0];
         IDX_CRC_HI:  frame_byte = crc_ff[15:8];
         default:     frame_byte = 8'h00;
      endcase
   end

   always_comb begin
      idx_in    = idx_ff;
      crc_in    = crc_ff;
      valid_in  = valid_ff;
      kind_in   = kind_ff;
      tx_in     = tx_ff;
      last_in   = last_ff;
      status_in = status_ff;
      value_in  = value_ff;
      pop       = 1'b0;

      if (adv) begin
         valid_in = 1'b1;
         if (head.is_report) begin
            kind_in   = KIND_REPORT;
            tx_in     = 8'h00;
            last_in   = 1'b0;
            status_in = head.status;
            value_in  = head.word;
            pop       = 1'b1;
         end else begin
            kind_in   = KIND_TX;
            tx_in     = frame_byte;
            last_in   = (idx_ff == IDX_CRC_HI);
            status_in = STATUS_OK;
            value_in  = 16'h0000;
            if (idx_ff == IDX_CRC_HI) begin
               pop    = 1'b1;
               idx_in = IDX_ADDR;
               crc_in = CRC_INIT;
            end else begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff < IDX_CRC_LO) begin
                  crc_in = crc16_byte(crc_ff, frame_byte);
               end
            end
         end
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= IDX_ADDR;
         crc_ff   <= CRC_INIT;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         crc_ff   <= crc_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      tx_ff     <= tx_in;
      last_ff   <= last_in;
      status_ff <= status_in;
      value_ff  <= value_in;
   end

endmodule

// ===== design/modbus_rtu_master_frame_engine.sv =====
// Modbus RTU master frame engine, top level. Each input event on req_ch is a read request,
// a write request, a received line byte or a timer tick; the block takes one event per
// cycle while its four-entry job queue has room. A request taken while idle yields eight
// transmit bytes (address, function, register, count or value, CRC low then high), issued
// one per cycle by the back end while rsp_ch takes them, with a byte-serial CRC step. A response
// byte or tick is handled in the cycle it is taken and yields at most one completion
// report. Requests while a transaction is open and bytes or ticks while idle give nothing.
// Results leave through a registered output stage, so a stalled rsp_ch does not stop
// input until the queue fills.
`include "assert_macros.svh"

module modbus_rtu_master_frame_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata,
   mrtu_req_if.sink    req_ch,
   mrtu_rsp_if.source  rsp_ch
);
   import mrtu_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   push_type  q_push;
   qstat_type q_stat;
   entry_type head;
   logic      pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SERVER_ADDRESS: cfg_in.server_address = csr_wdata[7:0];
            CSR_TIMEOUT_TICKS:  cfg_in.timeout_ticks  = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.server_address <= ADDR_RESET;
         cfg_ff.timeout_ticks  <= TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mrtu_front u_front (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .q_stat (q_stat),
      .q_push (q_push),
      .req_ch (req_ch)
   );

   mrtu_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_push (q_push),
      .pop    (pop),
      .head   (head),
      .q_stat (q_stat)
   );

   mrtu_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .q_stat (q_stat),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

   `ASSERT_IMPLIES(a_tx_clean, clock, reset, rsp_ch.valid && rsp_ch.kind == KIND_TX, rsp_ch.status == STATUS_OK && rsp_ch.read_value == 16'h0000)
   `ASSERT_IMPLIES(a_report_clean, clock, reset, rsp_ch.valid && rsp_ch.kind == KIND_REPORT, rsp_ch.tx_byte == 8'h00 && !rsp_ch.last)
   `ASSERT_IMPLIES(a_no_overflow, clock, reset, q_stat.full, !q_push.valid)
   `ASSERT_NEXT(a_queue_quiet, clock, reset, q_stat.count == '0 && !q_push.valid, q_stat.count == '0)

endmodule
